[design/uacp_hello_ack_responder_unit_assert.svh]
// Assertion macros shared by the responder's modules.
// Both sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef UACP_HELLO_ACK_RESPONDER_UNIT_ASSERT_SVH
`define UACP_HELLO_ACK_RESPONDER_UNIT_ASSERT_SVH

// A general property.
`define UACP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication that is checked in the same cycle.
`define UACP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[design/uacp_pkg.sv]
`default_nettype none

package uacp_pkg;

	localparam int BC_W        = 21;
	localparam int HDR_LEN     = 8;
	localparam int ACK_LEN     = 8 + 20;
	localparam int CNT_W       = $clog2(ACK_LEN);
	localparam int QUEUE_DEPTH = 4;

	localparam logic [BC_W-1:0] LBS_RESET = BC_W'(2048);
	localparam logic [23:0]     TYPE_HEL  = 24'h4C4548;

	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_CONNECT = 1'b1;

	localparam logic KIND_ACK   = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic       out_kind;
		logic [7:0] out_byte;
		logic       last;
	} tx_item_t;

	// One job for the transmit side: a close, or an acknowledge with its sizes.
	typedef struct packed {
		logic            close;
		logic [BC_W-1:0] send_size;
		logic [BC_W-1:0] recv_size;
		logic [BC_W-1:0] max_msg;
	} uacp_evt_t;

endpackage

`default_nettype wire

[design/uacp_chan_if.sv]
`default_nettype none

interface uacp_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/uacp_hello_ack_responder_unit.sv]
// Hello/acknowledge responder for one connection. The rx channel takes one beat per cycle: a
// received byte, or a new-connection command that clears all parse state. A parser frames
// messages by their 8-byte header, keeps the client sizes of a hello message and, on the
// header's last byte or the message's last byte, queues a job: a close (bad size, or a hello
// shorter than 28 bytes) or a 28-byte acknowledge. A transmit serialiser drains the job queue
// (QUEUE_DEPTH entries, default four) and sends one result beat per cycle on tx: one beat for a
// close, 28 for an acknowledge, with last set on the final beat. A job's first beat is loaded
// once it is queued and the tx register is free. rx accepts a beat every cycle while the queue
// has room; a long tx stall fills the queue and then holds rx ready low. After a close, bytes
// are dropped silently until the next new-connection command. cfg writes local_buf_size (reset
// 2048) and is always ready; write it only while no results are outstanding.
`default_nettype none

module uacp_hello_ack_responder_unit #(
	parameter int QUEUE_DEPTH = uacp_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	uacp_chan_if.sink   rx,
	uacp_chan_if.sink   cfg,
	uacp_chan_if.source tx
);
	import uacp_pkg::*;

	logic [BC_W-1:0] lbs_q;
	uacp_evt_t       push_evt;
	uacp_evt_t       head_evt;
	logic            push;
	logic            pop;
	logic            queue_full;
	logic            queue_empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbs_q <= LBS_RESET;
		end else if (cfg.valid) begin
			lbs_q <= cfg.data;
		end
	end

	uacp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.lbs        (lbs_q),
		.queue_full (queue_full),
		.push       (push),
		.evt        (push_evt)
	);

	uacp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_evt),
		.pop     (pop),
		.rd_data (head_evt),
		.full    (queue_full),
		.empty   (queue_empty)
	);

	uacp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (!queue_empty),
		.evt       (head_evt),
		.pop       (pop),
		.tx        (tx)
	);

endmodule

`default_nettype wire

[design/uacp_queue.sv]
`default_nettype none

module uacp_queue #(
	parameter int DEPTH = uacp_pkg::QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  uacp_pkg::uacp_evt_t wr_data,
	input  wire                 pop,
	output uacp_pkg::uacp_evt_t rd_data,
	output logic                full,
	output logic                empty
);
	import uacp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	uacp_evt_t          mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;

	assign full    = (count_q == CNT_QW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/uacp_front.sv]
`default_nettype none
`include "uacp_hello_ack_responder_unit_assert.svh"

module uacp_front (
	input  wire                   clk,
	input  wire                   arst_n,
	uacp_chan_if.sink             rx,
	input  wire [uacp_pkg::BC_W-1:0] lbs,
	input  wire                   queue_full,
	output logic                  push,
	output uacp_pkg::uacp_evt_t   evt
);
	import uacp_pkg::*;

	logic [BC_W-1:0] byte_count_q;
	logic [23:0]     msg_type_q;
	logic [31:0]     msg_size_q;
	logic [31:0]     recv_q;
	logic [31:0]     send_q;
	logic [31:0]     max_q;
	logic            closed_q;

	logic [23:0]     type_nx;
	logic [31:0]     size_nx;
	logic [31:0]     recv_nx;
	logic [31:0]     send_nx;
	logic [31:0]     max_nx;
	logic [BC_W:0]   pos_inc;
	logic [7:0]      b;
	logic [4:0]      lane;
	logic            fire;
	logic            bad_size;
	logic            msg_end;

	// Zero from the client means take our size, otherwise the smaller one.
	function automatic logic [BC_W-1:0] negotiate(input logic [31:0] c,
			input logic [BC_W-1:0] ours);
		logic take_ours;
		take_ours = (c == '0) || (c > 32'(ours));
		return take_ours ? ours : c[BC_W-1:0];
	endfunction

	assign rx.ready = !queue_full;
	assign fire     = rx.valid && rx.ready;
	assign b        = rx.data.rx_byte;
	assign lane     = {byte_count_q[1:0], 3'b000};
	assign pos_inc  = {1'b0, byte_count_q} + 1'b1;

	always_comb begin
		type_nx = msg_type_q;
		size_nx = msg_size_q;
		recv_nx = recv_q;
		send_nx = send_q;
		max_nx  = max_q;
		if (byte_count_q == '0) begin
			type_nx = {16'h0000, b};
			size_nx = '0;
		end else if (byte_count_q < BC_W'(3)) begin
			type_nx[lane +: 8] = b;
		end else if (byte_count_q >= BC_W'(4) && byte_count_q < BC_W'(HDR_LEN)) begin
			size_nx[lane +: 8] = b;
		end else if (byte_count_q >= BC_W'(12) && byte_count_q < BC_W'(16)) begin
			recv_nx[lane +: 8] = b;
		end else if (byte_count_q >= BC_W'(16) && byte_count_q < BC_W'(20)) begin
			send_nx[lane +: 8] = b;
		end else if (byte_count_q >= BC_W'(20) && byte_count_q < BC_W'(24)) begin
			max_nx[lane +: 8] = b;
		end
		// Each client field is cleared on the byte before its first one.
		if (byte_count_q == BC_W'(11)) begin
			recv_nx = '0;
		end
		if (byte_count_q == BC_W'(15)) begin
			send_nx = '0;
		end
		if (byte_count_q == BC_W'(19)) begin
			max_nx = '0;
		end
	end

	assign bad_size = (byte_count_q == BC_W'(HDR_LEN - 1))
			&& (size_nx < 32'(HDR_LEN) || size_nx > 32'(lbs));
	assign msg_end  = (byte_count_q >= BC_W'(HDR_LEN - 1)) && (32'(pos_inc) >= size_nx);

	assign push = fire && (rx.data.command == CMD_BYTE) && !closed_q
			&& (bad_size || (msg_end && type_nx == TYPE_HEL));

	always_comb begin
		evt.close     = bad_size || (size_nx < 32'(ACK_LEN));
		evt.send_size = negotiate(send_q, lbs);
		evt.recv_size = negotiate(recv_q, lbs);
		evt.max_msg   = negotiate(max_q, lbs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			msg_type_q   <= '0;
			msg_size_q   <= '0;
			recv_q       <= '0;
			send_q       <= '0;
			max_q        <= '0;
			closed_q     <= 1'b0;
		end else if (fire) begin
			if (rx.data.command == CMD_CONNECT) begin
				byte_count_q <= '0;
				msg_type_q   <= '0;
				msg_size_q   <= '0;
				recv_q       <= '0;
				send_q       <= '0;
				max_q        <= '0;
				closed_q     <= 1'b0;
			end else if (!closed_q) begin
				msg_type_q <= type_nx;
				msg_size_q <= size_nx;
				recv_q     <= recv_nx;
				send_q     <= send_nx;
				max_q      <= max_nx;
				if (bad_size) begin
					closed_q <= 1'b1;
				end else if (msg_end) begin
					byte_count_q <= '0;
					if (type_nx == TYPE_HEL && size_nx < 32'(ACK_LEN)) begin
						closed_q <= 1'b1;
					end
				end else begin
					byte_count_q <= pos_inc[BC_W-1:0];
				end
			end
		end
	end

	`UACP_ASSERT_IMP(a_closed_silent, fire && closed_q && rx.data.command == CMD_BYTE, !push, "job from a closed connection")
	`UACP_ASSERT(a_connect_clears, (fire && rx.data.command == CMD_CONNECT) |=> (byte_count_q == '0 && !closed_q), "parser not cleared")
	`UACP_ASSERT_IMP(a_ack_late, push && !evt.close, byte_count_q >= BC_W'(ACK_LEN - 1), "early acknowledge job")

endmodule

`default_nettype wire

[design/uacp_back.sv]
`default_nettype none
`include "uacp_hello_ack_responder_unit_assert.svh"

module uacp_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 evt_valid,
	input  uacp_pkg::uacp_evt_t evt,
	output logic                pop,
	uacp_chan_if.source         tx
);
	import uacp_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             tx_valid_q;
	tx_item_t         tx_data_q;
	tx_item_t         beat_d;
	logic             load;
	logic             last_beat;
	logic [31:0]      word;

	// Acknowledge message as little-endian words: "ACKF", size, 0, the three
	// negotiated sizes, and the chunk count of one.
	function automatic logic [31:0] ack_word(input uacp_evt_t e, input logic [2:0] w);
		logic [31:0] r;
		unique case (w)
			3'd0:    r = 32'h464B4341;
			3'd1:    r = 32'(ACK_LEN);
			3'd2:    r = 32'h0;
			3'd3:    r = 32'(e.send_size);
			3'd4:    r = 32'(e.recv_size);
			3'd5:    r = 32'(e.max_msg);
			3'd6:    r = 32'h1;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	assign load      = evt_valid && (!tx_valid_q || tx.ready);
	assign last_beat = evt.close || (cnt_q == CNT_W'(ACK_LEN - 1));
	assign pop       = load && last_beat;
	assign word      = ack_word(evt, cnt_q[CNT_W-1:2]);

	always_comb begin
		if (evt.close) begin
			beat_d.out_kind = KIND_CLOSE;
			beat_d.out_byte = 8'h00;
			beat_d.last     = 1'b1;
		end else begin
			beat_d.out_kind = KIND_ACK;
			beat_d.out_byte = word[{cnt_q[1:0], 3'b000} +: 8];
			beat_d.last     = last_beat;
		end
	end

	assign tx.valid = tx_valid_q;
	assign tx.data  = tx_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (!tx_valid_q || tx.ready) begin
				tx_valid_q <= evt_valid;
			end
			if (load) begin
				cnt_q <= last_beat ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_data_q <= beat_d;
		end
	end

	`UACP_ASSERT(a_cnt_range, cnt_q < CNT_W'(ACK_LEN), "beat counter ran past the acknowledge length")
	`UACP_ASSERT_IMP(a_close_shape, tx_valid_q && tx_data_q.out_kind == KIND_CLOSE, tx_data_q.out_byte == 8'h00 && tx_data_q.last, "malformed close beat")
	`UACP_ASSERT_IMP(a_idle_cnt, !evt_valid, cnt_q == '0, "beat counter left mid-message with no job queued")

endmodule

`default_nettype wire

[tb/uacp_hello_ack_responder_unit_tb.sv]
`timescale 1ns / 100ps

module uacp_hello_ack_responder_unit_tb;
	import uacp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASES       = 6;
	localparam int ITEMS_PER_PH = 10;
	localparam int SETTLE       = 8;
	localparam int TAIL         = 40;

	typedef logic [7:0] byte_q_t[$];
	typedef enum int {PACE_FREE, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

	// Tracks the parser of one connection and holds the transmit beats it should cause.
	class responder_scoreboard;
		logic [BC_W-1:0] buf_size;
		logic [BC_W-1:0] pos_count;
		logic [23:0]     type_word;
		logic [31:0]     size_word;
		logic [31:0]     recv_word;
		logic [31:0]     send_word;
		logic [31:0]     max_word;
		bit              closed;
		tx_item_t        tx_expected[$];
		int              mismatches;
		int              beats_seen;

		function new();
			buf_size   = LBS_RESET;
			mismatches = 0;
			beats_seen = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			pos_count = '0;
			type_word = '0;
			size_word = '0;
			recv_word = '0;
			send_word = '0;
			max_word  = '0;
			closed    = 1'b0;
		endfunction

		function logic [31:0] negotiated(logic [31:0] client);
			logic [31:0] ours;
			ours = 32'(buf_size);
			if (client == 0)
				return ours;
			return (client < ours) ? client : ours;
		endfunction

		function void queue_close();
			tx_item_t t;
			closed     = 1'b1;
			t.out_kind = KIND_CLOSE;
			t.out_byte = 8'h00;
			t.last     = 1'b1;
			tx_expected.push_back(t);
		endfunction

		function void queue_ack();
			logic [31:0] words[7];
			tx_item_t    t;
			int          i;
			// The type word holds the four characters first byte lowest.
			words[0] = {"F", "K", "C", "A"};
			words[1] = 32'(ACK_LEN);
			words[2] = 32'd0;
			words[3] = negotiated(send_word);
			words[4] = negotiated(recv_word);
			words[5] = negotiated(max_word);
			words[6] = 32'd1;
			for (i = 0; i < ACK_LEN; i++) begin
				t.out_kind = KIND_ACK;
				t.out_byte = words[i / 4][8 * (i % 4) +: 8];
				t.last     = (i == ACK_LEN - 1);
				tx_expected.push_back(t);
			end
		endfunction

		function void note_rx(rx_item_t it);
			logic [31:0] p;
			logic [31:0] b;
			int          sh;
			if (it.command == CMD_CONNECT) begin
				clear_parse();
				return;
			end
			if (closed)
				return;
			p = 32'(pos_count);
			b = 32'(it.rx_byte);
			if (p == 0) begin
				type_word = 24'(it.rx_byte);
				size_word = '0;
			end else if (p < 3) begin
				type_word |= 24'(b << (8 * p));
			end else if (p >= 4 && p < 8) begin
				size_word |= b << (8 * (p - 4));
			end else if (p >= 12 && p < 24) begin
				sh = int'(8 * ((p - 12) % 4));
				if (p < 16)
					recv_word |= b << sh;
				else if (p < 20)
					send_word |= b << sh;
				else
					max_word |= b << sh;
			end
			// Each hello size field is cleared on the byte just ahead of it.
			if (p == 11)
				recv_word = '0;
			else if (p == 15)
				send_word = '0;
			else if (p == 19)
				max_word = '0;

			if (p == HDR_LEN - 1 && (size_word < HDR_LEN || size_word > 32'(buf_size))) begin
				queue_close();
				return;
			end
			if (p + 1 >= HDR_LEN && p + 1 >= size_word) begin
				pos_count = '0;
				if (type_word == TYPE_HEL) begin
					if (size_word < ACK_LEN)
						queue_close();
					else
						queue_ack();
				end
				return;
			end
			pos_count = BC_W'(p + 1);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("mismatch at tx beat %0d: %s", beats_seen, what);
		endtask

		task check_tx(tx_item_t got);
			tx_item_t want;
			beats_seen++;
			if (tx_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected beat kind %0b byte %02h last %0b",
					got.out_kind, got.out_byte, got.last));
				return;
			end
			want = tx_expected.pop_front();
			if (got.out_kind !== want.out_kind)
				report_mismatch($sformatf("out_kind %0b, expected %0b", got.out_kind, want.out_kind));
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	uacp_chan_if #(.T(rx_item_t))        rx_if ();
	uacp_chan_if #(.T(logic [BC_W-1:0])) cfg_if ();
	uacp_chan_if #(.T(tx_item_t))        tx_if ();

	uacp_hello_ack_responder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.cfg    (cfg_if),
		.tx     (tx_if)
	);

	responder_scoreboard sb = new();

	int unsigned     cycle_count = 0;
	int              src_idle_pct = 0;
	int              sink_stall_pct = 0;
	int              items_sent = 0;
	logic [BC_W-1:0] cur_buf_size = LBS_RESET;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: ready changes only at rising edges, so at the falling edge the
	// handshake seen is the one the next rising edge will take.
	initial begin
		tx_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tx_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	always @(negedge clk) begin
		if (arst_n && tx_if.valid && tx_if.ready)
			sb.check_tx(tx_if.data);
	end

	// Called at a rising edge; returns at the rising edge that takes the beat.
	task automatic send_rx(input logic cmd, input logic [7:0] value);
		rx_item_t it;
		it.command = cmd;
		it.rx_byte = value;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.data  <= it;
		@(negedge clk);
		while (!rx_if.ready)
			@(negedge clk);
		sb.note_rx(it);
		items_sent++;
		@(posedge clk);
	endtask

	task automatic send_connect();
		send_rx(CMD_CONNECT, 8'($urandom));
	endtask

	task automatic wait_drained(input int tail);
		rx_if.valid <= 1'b0;
		while (sb.tx_expected.size() != 0)
			@(posedge clk);
		repeat (tail)
			@(posedge clk);
	endtask

	task automatic write_buf_size(input logic [BC_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= value;
		@(negedge clk);
		while (!cfg_if.ready)
			@(negedge clk);
		sb.buf_size  = value;
		cur_buf_size = value;
		@(posedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_client_size();
		case ($urandom_range(0, 4))
			0:       return 32'd0;
			1:       return $urandom();
			2:       return $urandom_range(1, 64);
			3:       return 32'(cur_buf_size) - 1 + $urandom_range(0, 2);
			default: return $urandom_range(1, 32'(cur_buf_size) * 2 + 1);
		endcase
	endfunction

	function automatic logic [23:0] other_type();
		logic [23:0] t;
		if ($urandom_range(0, 1) != 0)
			t = TYPE_HEL ^ (24'd1 << $urandom_range(0, 23));
		else
			t = 24'($urandom);
		if (t == TYPE_HEL)
			t[0] = ~t[0];
		return t;
	endfunction

	// Header, four filler bytes, then the three hello size fields and padding.
	function automatic byte_q_t build_message(logic [23:0] kind, logic [31:0] size, int nbytes);
		byte_q_t     q;
		logic [31:0] sizes[3];
		int          i;
		int          f;
		for (f = 0; f < 3; f++)
			sizes[f] = pick_client_size();
		q = {};
		for (i = 0; i < 3; i++)
			q.push_back(kind[8 * i +: 8]);
		q.push_back(8'($urandom));
		for (i = 0; i < 4; i++)
			q.push_back(size[8 * i +: 8]);
		for (i = 0; i < 4; i++)
			q.push_back(8'($urandom));
		for (f = 0; f < 3; f++)
			for (i = 0; i < 4; i++)
				q.push_back(sizes[f][8 * i +: 8]);
		while (q.size() < nbytes)
			q.push_back(8'($urandom));
		while (q.size() > nbytes)
			void'(q.pop_back());
		return q;
	endfunction

	// A message whose header or length closes the connection, or one cut short,
	// is followed by a new connection.
	task automatic send_message(input logic [23:0] kind, input logic [31:0] size, input int cut);
		byte_q_t msg;
		int      nbytes;
		bit      broken;
		broken = (size < HDR_LEN) || (size > 32'(cur_buf_size)) ||
			(kind == TYPE_HEL && size < ACK_LEN);
		if (size < HDR_LEN || size > 32'(cur_buf_size))
			nbytes = HDR_LEN + $urandom_range(0, 3);
		else
			nbytes = int'(size);
		if (cut > 0 && cut < nbytes) begin
			nbytes = cut;
			broken = 1'b1;
		end
		msg = build_message(kind, size, nbytes);
		foreach (msg[i])
			send_rx(CMD_BYTE, msg[i]);
		if (broken)
			send_connect();
	endtask

	initial begin
		logic [BC_W-1:0] phase_sizes[PHASES];
		pace_t           pace;
		logic [31:0]     size;
		int              sel;
		int              start;
		int              n;
		bit              drained;

		rx_if.valid  <= 1'b0;
		rx_if.data   <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data  <= '0;

		phase_sizes[0] = LBS_RESET;
		phase_sizes[1] = BC_W'(ACK_LEN);
		phase_sizes[2] = BC_W'(1 << 20);
		phase_sizes[3] = '1;
		phase_sizes[4] = BC_W'($urandom_range(ACK_LEN + 1, 100000));
		phase_sizes[5] = BC_W'(5);

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			pace = pace_t'(ph % 4);
			src_idle_pct   = (pace == PACE_SRC_IDLE) ? 60 : (pace == PACE_BOTH) ? 23 : 0;
			sink_stall_pct = (pace == PACE_SNK_STALL) ? 60 : (pace == PACE_BOTH) ? 23 : 0;
			if (ph == 0) begin
				// Size below the header, a header-only message, a hello too short to answer.
				send_message(TYPE_HEL, 32'd7, 0);
				send_message({"G", "S", "M"}, 32'(HDR_LEN), 0);
				send_message(TYPE_HEL, 32'(HDR_LEN), 0);
			end else begin
				wait_drained(SETTLE);
				write_buf_size(phase_sizes[ph]);
				send_connect();
			end

			start   = items_sent;
			drained = 1'b0;
			while (items_sent - start < ITEMS_PER_PH) begin
				sel = $urandom_range(0, 99);
				if (sel < 45) begin
					size = ACK_LEN + $urandom_range(0, 6);
					if (size > 32'(cur_buf_size) && cur_buf_size >= ACK_LEN)
						size = 32'(cur_buf_size);
					send_message(TYPE_HEL, size, 0);
					if (!drained) begin
						wait_drained(0);
						drained = 1'b1;
					end
				end else if (sel < 65) begin
					send_message(other_type(), $urandom_range(HDR_LEN, 16), 0);
				end else if (sel < 75) begin
					case ($urandom_range(0, 2))
						0:       size = $urandom_range(0, HDR_LEN - 1);
						1:       size = 32'(cur_buf_size) + 1 + $urandom_range(0, 3);
						default: size = $urandom() | 32'h8000_0000;
					endcase
					send_message(($urandom_range(0, 1) != 0) ? TYPE_HEL : other_type(), size, 0);
				end else if (sel < 83) begin
					send_message(TYPE_HEL, $urandom_range(HDR_LEN, ACK_LEN - 1), 0);
				end else if (sel < 90) begin
					send_message(TYPE_HEL, ACK_LEN + $urandom_range(0, 4), $urandom_range(1, 20));
				end else if (sel < 95) begin
					n = $urandom_range(1, 4);
					repeat (n)
						send_rx(CMD_BYTE, 8'($urandom));
					send_connect();
				end else begin
					send_connect();
				end
			end
		end

		wait_drained(TAIL);
		if (sb.mismatches == 0 && sb.tx_expected.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
